[src/xcfd_pkg.sv]
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the XOR-checked frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfd_pkg;

   // Result queue depth; must stay a power of two of at least 4
   localparam int unsigned RSP_DEPTH = 4;

   // Frame positions that matter
   localparam logic [8:0] POS_PROTO      = 9'd0;
   localparam logic [8:0] POS_LENGTH     = 9'd1;
   localparam logic [8:0] POS_CMD_HI     = 9'd2;
   localparam logic [8:0] POS_CMD_LO     = 9'd3;
   localparam logic [8:0] POS_FIRST_EMIT = 9'd5;
   localparam logic [8:0] MIN_LAST_POS   = 9'd3;   // frame of at least four bytes
   localparam logic [8:0] BYTE_COUNT_MAX = 9'h1FF;
   localparam logic [7:0] EMIT_COUNT_MAX = 8'hFF;
   localparam logic [7:0] PROTO_ID       = 8'h00;

   // Result kind, carried on tuser
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_SHORT = 3'd1,
      STATUS_BAD_PROTO = 3'd2,
      STATUS_BAD_LEN   = 3'd3,
      STATUS_BAD_CSUM  = 3'd4
   } status_type;

   // One queued result
   typedef struct packed {
      logic        kind;
      logic        last;
      logic [7:0]  payload;
      status_type  status;
      logic [15:0] command;
      logic [7:0]  count;
   } rsp_entry_type;

   localparam int unsigned RSP_DATA_W = 40;   // 35 field bits padded to bytes

endpackage

[src/xor_checked_frame_deframer.sv]
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Byte-stream deframer for length-prefixed frames with an XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one frame byte per transaction; req_tlast marks the final
//   (checksum) byte. rsp_* carries results: tuser 0 is a payload byte, tuser 1
//   is the frame verdict (status, command, payload count). rsp_tlast marks the
//   last result caused by one input byte.
//   Payload bytes leave one byte late, so the checksum is never forwarded. A
//   verdict other than ok means the payload already sent should be dropped.
//   A result enters the queue when its byte is taken; rsp_* shows the head.
//   Throughput: one byte per cycle while req_tready is high; a final byte
//   yielding a payload and a verdict queues two results on the single port.
//   Results sit in a four-entry queue; req_tready is high while at least two
//   entries are free, so input keeps flowing while a result waits.
//   When the receiver stalls, the queue fills and req_tready drops; nothing is
//   lost. Reset (synchronous) empties the queue and clears all frame state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_checked_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // Input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [xcfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
                                    // [7:0] payload_byte, [10:8] status,
                                    // [26:11] command_code, [34:27] payload_count,
                                    // [39:35] zero
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last_result
);

   localparam int unsigned PTR_W = $clog2(xcfd_pkg::RSP_DEPTH);
   localparam int unsigned CNT_W = $clog2(xcfd_pkg::RSP_DEPTH + 1);

   // Frame state
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] command_ff, command_in;
   logic        proto_bad_ff, proto_bad_in;
   logic [7:0]  emitted_ff, emitted_in;

   // Result queue
   xcfd_pkg::rsp_entry_type rsp_q_ff [xcfd_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] q_count_ff, q_count_in;

   logic req_xact, rsp_xact;
   logic emit, push_verdict;
   logic [1:0] push_count;
   xcfd_pkg::rsp_entry_type payload_entry, verdict_entry, head_entry;
   xcfd_pkg::status_type    status;
   logic [8:0] length_ext, size_minus_two;

   assign req_tready = (q_count_ff <= CNT_W'(xcfd_pkg::RSP_DEPTH - 2));
   assign req_xact   = req_tvalid & req_tready;
   assign rsp_xact   = rsp_tvalid & rsp_tready;

   // Header capture, running checks, result entries and next frame state
   always_comb begin
      emit         = (byte_count_ff >= xcfd_pkg::POS_FIRST_EMIT);
      push_verdict = req_tlast;

      proto_bad_in = proto_bad_ff |
                     ((byte_count_ff == xcfd_pkg::POS_PROTO) &&
                      (req_tdata != xcfd_pkg::PROTO_ID));
      length_in    = (byte_count_ff == xcfd_pkg::POS_LENGTH) ? req_tdata : length_ff;
      command_in   = command_ff;
      if (byte_count_ff == xcfd_pkg::POS_CMD_HI) begin
         command_in[15:8] = req_tdata;
      end
      if (byte_count_ff == xcfd_pkg::POS_CMD_LO) begin
         command_in[7:0] = req_tdata;
      end
      emitted_in = (emit && (emitted_ff != xcfd_pkg::EMIT_COUNT_MAX)) ?
                   emitted_ff + 8'd1 : emitted_ff;

      // frame size minus two equals position minus one
      length_ext     = {1'b0, length_in};
      size_minus_two = byte_count_ff - 9'd1;

      if (byte_count_ff < xcfd_pkg::MIN_LAST_POS) begin
         status = xcfd_pkg::STATUS_TOO_SHORT;
      end else if (proto_bad_in) begin
         status = xcfd_pkg::STATUS_BAD_PROTO;
      end else if (size_minus_two != length_ext) begin
         status = xcfd_pkg::STATUS_BAD_LEN;
      end else if (running_xor_ff != req_tdata) begin
         status = xcfd_pkg::STATUS_BAD_CSUM;
      end else begin
         status = xcfd_pkg::STATUS_OK;
      end

      payload_entry.kind    = xcfd_pkg::KIND_PAYLOAD;
      payload_entry.last    = ~req_tlast;
      payload_entry.payload = held_byte_ff;
      payload_entry.status  = xcfd_pkg::STATUS_OK;
      payload_entry.command = 16'd0;
      payload_entry.count   = 8'd0;

      verdict_entry.kind    = xcfd_pkg::KIND_VERDICT;
      verdict_entry.last    = 1'b1;
      verdict_entry.payload = 8'd0;
      verdict_entry.status  = status;
      verdict_entry.command = (status == xcfd_pkg::STATUS_TOO_SHORT) ? 16'd0 : command_in;
      verdict_entry.count   = emitted_in;

      // next frame state: cleared after a verdict
      if (req_tlast) begin
         byte_count_in  = 9'd0;
         running_xor_in = 8'd0;
         held_byte_in   = 8'd0;
      end else begin
         byte_count_in  = (byte_count_ff != xcfd_pkg::BYTE_COUNT_MAX) ?
                          byte_count_ff + 9'd1 : byte_count_ff;
         running_xor_in = running_xor_ff ^ req_tdata;
         held_byte_in   = req_tdata;
      end

      push_count = req_xact ? ({1'b0, emit} + {1'b0, push_verdict}) : 2'd0;
      q_count_in = q_count_ff + CNT_W'(push_count) - CNT_W'(rsp_xact);
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         running_xor_ff <= '0;
         held_byte_ff   <= '0;
         length_ff      <= '0;
         command_ff     <= '0;
         proto_bad_ff   <= 1'b0;
         emitted_ff     <= '0;
      end else if (req_xact) begin
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
         held_byte_ff   <= held_byte_in;
         length_ff      <= req_tlast ? 8'd0 : length_in;
         command_ff     <= req_tlast ? 16'd0 : command_in;
         proto_bad_ff   <= req_tlast ? 1'b0 : proto_bad_in;
         emitted_ff     <= req_tlast ? 8'd0 : emitted_in;
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      if (req_xact) begin
         if (emit) begin
            rsp_q_ff[wr_ptr_ff] <= payload_entry;
            if (push_verdict) begin
               rsp_q_ff[PTR_W'(wr_ptr_ff + 1'b1)] <= verdict_entry;
            end
         end else if (push_verdict) begin
            rsp_q_ff[wr_ptr_ff] <= verdict_entry;
         end
      end
   end

   // Result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_ff + PTR_W'(push_count);
         rd_ptr_ff  <= rd_ptr_ff + PTR_W'(rsp_xact);
         q_count_ff <= q_count_in;
      end
   end

   // Output from queue head
   assign head_entry = rsp_q_ff[rd_ptr_ff];
   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tuser  = head_entry.kind;
   assign rsp_tlast  = head_entry.last;
   assign rsp_tdata  = {5'd0, head_entry.count, head_entry.command,
                        head_entry.status, head_entry.payload};

   // Checks
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= CNT_W'(xcfd_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == xcfd_pkg::KIND_VERDICT)) |-> rsp_tlast)
      else $error("verdict not marked last");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == xcfd_pkg::KIND_PAYLOAD)) |->
      (rsp_tdata[39:8] == 32'd0))
      else $error("payload result carries verdict fields");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (req_xact && req_tlast) |=> (byte_count_ff == 9'd0 && emitted_ff == 8'd0))
      else $error("frame state not cleared after verdict");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      req_xact |-> (q_count_ff + CNT_W'(push_count) <=
                    CNT_W'(xcfd_pkg::RSP_DEPTH)))
      else $error("push without room");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xor_checked_frame_deframer: frame bytes go in on
// req_*, and every payload byte and frame verdict on rsp_* is compared with a
// cycle-free model of the deframer that lives in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   // Kinds of frame the generator can build
   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_PROTO,
      FRAME_BAD_LEN,
      FRAME_BAD_CSUM,
      FRAME_NOISE
   } frame_flavor_type;

   // One expected result, field by field
   typedef struct {
      logic                 kind;
      logic [7:0]           payload;
      xcfd_pkg::status_type status;
      logic [15:0]          command;
      logic [7:0]           count;
      logic                 last;
   } rsp_fields_type;

   // -------------------------------------------------------------------------
   // Deframer model and result checker
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      logic [8:0]  frame_pos;
      logic [7:0]  xor_acc;
      logic [7:0]  held;
      logic [7:0]  len_byte;
      logic [15:0] cmd;
      logic        proto_bad;
      logic [7:0]  emitted;
      rsp_fields_type pending[$];
      int errors;
      int frames;
      int payloads;
      int status_seen[5];

      function new();
         errors   = 0;
         frames   = 0;
         payloads = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_pos = '0;
         xor_acc   = '0;
         held      = '0;
         len_byte  = '0;
         cmd       = '0;
         proto_bad = 1'b0;
         emitted   = '0;
      endfunction

      // Accepted input byte: advance the model and queue what it yields
      function void note_byte(logic [7:0] d, logic l);
         rsp_fields_type r;
         xcfd_pkg::status_type st;
         logic [15:0] cmd_out;
         if (frame_pos == xcfd_pkg::POS_PROTO && d != xcfd_pkg::PROTO_ID) proto_bad = 1'b1;
         if (frame_pos == xcfd_pkg::POS_LENGTH) len_byte = d;
         if (frame_pos == xcfd_pkg::POS_CMD_HI) cmd[15:8] = d;
         if (frame_pos == xcfd_pkg::POS_CMD_LO) cmd[7:0] = d;

         // held byte leaves one byte late
         if (frame_pos >= xcfd_pkg::POS_FIRST_EMIT) begin
            if (emitted != xcfd_pkg::EMIT_COUNT_MAX) emitted++;
            r.kind    = xcfd_pkg::KIND_PAYLOAD;
            r.payload = held;
            r.status  = xcfd_pkg::STATUS_OK;
            r.command = '0;
            r.count   = '0;
            r.last    = !l;
            pending.insert(pending.size(), r);
         end

         if (l) begin
            cmd_out = cmd;
            if (frame_pos < xcfd_pkg::MIN_LAST_POS) begin
               st      = xcfd_pkg::STATUS_TOO_SHORT;
               cmd_out = '0;
            end else if (proto_bad) begin
               st = xcfd_pkg::STATUS_BAD_PROTO;
            end else if ((frame_pos - 9'd1) != {1'b0, len_byte}) begin
               // frame size minus two, against the length byte
               st = xcfd_pkg::STATUS_BAD_LEN;
            end else if (xor_acc != d) begin
               st = xcfd_pkg::STATUS_BAD_CSUM;
            end else begin
               st = xcfd_pkg::STATUS_OK;
            end
            r.kind    = xcfd_pkg::KIND_VERDICT;
            r.payload = '0;
            r.status  = st;
            r.command = cmd_out;
            r.count   = emitted;
            r.last    = 1'b1;
            pending.insert(pending.size(), r);
            clear_frame();
         end else begin
            xor_acc = xor_acc ^ d;
            held    = d;
            if (frame_pos != xcfd_pkg::BYTE_COUNT_MAX) frame_pos++;
         end
      endfunction

      function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, fname, want, got);
            errors++;
         end
      endfunction

      // Accepted result: compare with the oldest expectation
      function void check_result(logic kind, logic [39:0] data, logic last);
         rsp_fields_type e;
         if (pending.size() == 0) begin
            $display("%0t ns: unexpected result, expected none actual kind %0d data %h",
                     $time, kind, data);
            errors++;
            return;
         end
         e = pending.pop_front();
         compare_field("result_kind", 16'(e.kind), 16'(kind));
         compare_field("payload_byte", 16'(e.payload), 16'(data[7:0]));
         compare_field("status", 16'(e.status), 16'(data[10:8]));
         compare_field("command_code", e.command, data[26:11]);
         compare_field("payload_count", 16'(e.count), 16'(data[34:27]));
         compare_field("last_result", 16'(e.last), 16'(last));
         if (e.kind == xcfd_pkg::KIND_VERDICT) begin
            frames++;
            status_seen[e.status]++;
         end else begin
            payloads++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] data_byte
   logic        req_tlast = 1'b0;  // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;         // [7:0] payload, [10:8] status, [26:11] command,
                                   // [34:27] count, [39:35] zero
   logic        rsp_tuser;         // result_kind
   logic        rsp_tlast;         // last_result

   frame_scoreboard sb = new();
   bit  idle_on = 1'b1;
   int  rsp_hold_len = 0;
   int  bytes_sent = 0;

   always #5 clock = ~clock;

   xor_checked_frame_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // -------------------------------------------------------------------------
   // Result side: check each transaction, random stalls, one long hold-off
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
      if (rsp_hold_len > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_len--;
      end else if (idle_on && $urandom_range(99) < 17) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Input side
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] d, input logic l);
      while (idle_on && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(d, l);
      bytes_sent++;
   endtask

   // Build one frame; fill < 0 means random body bytes
   task automatic send_frame(input int size, input frame_flavor_type flavor,
                             input int fill);
      logic [7:0] b[];
      logic [7:0] x;
      b = new[size];
      foreach (b[i]) b[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (flavor != FRAME_NOISE) begin
         b[0] = (flavor == FRAME_BAD_PROTO) ? 8'($urandom_range(255, 1)) : xcfd_pkg::PROTO_ID;
         if (size > 1) begin
            b[1] = 8'(size - 2);
            if (flavor == FRAME_BAD_LEN) b[1] = b[1] + 8'($urandom_range(255, 1));
         end
         x = '0;
         for (int i = 0; i < size - 1; i++) x ^= b[i];
         if (flavor == FRAME_BAD_CSUM) x ^= 8'($urandom_range(255, 1));
         b[size - 1] = x;
      end
      for (int i = 0; i < size; i++) send_byte(b[i], i == size - 1);
   endtask

   // Stop offering input until every expected result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_frame();
      int r;
      int size;
      frame_flavor_type flavor;
      r = $urandom_range(99);
      if (r < 5)       size = $urandom_range(3, 1);
      else if (r < 85) size = $urandom_range(12, 4);
      else             size = $urandom_range(48, 13);
      r = $urandom_range(99);
      if (r < 70)      flavor = FRAME_GOOD;
      else if (r < 78) flavor = FRAME_BAD_PROTO;
      else if (r < 86) flavor = FRAME_BAD_LEN;
      else if (r < 94) flavor = FRAME_BAD_CSUM;
      else             flavor = FRAME_NOISE;
      send_frame(size, flavor, -1);
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short frames, four-byte frame, first payload, error paths
      send_frame(1, FRAME_NOISE, 8'hFF);
      send_frame(3, FRAME_BAD_PROTO, -1);
      send_frame(4, FRAME_GOOD, 8'hFF);
      send_frame(6, FRAME_GOOD, 8'h00);
      send_frame(5, FRAME_BAD_LEN, -1);
      send_frame(6, FRAME_BAD_CSUM, -1);
      drain();

      // receiver holds off while the sender keeps pushing
      idle_on = 1'b0;
      rsp_hold_len = 60;
      send_frame(20, FRAME_GOOD, -1);
      send_frame(12, FRAME_BAD_CSUM, -1);
      idle_on = 1'b1;
      drain();

      // random phases; phase 2 runs without idling, long frames in between
      for (int phase = 0; phase < 4; phase++) begin
         int start_count;
         start_count = bytes_sent;
         idle_on = (phase != 2);
         if (phase == 1) send_frame(257, FRAME_GOOD, -1);   // longest legal length
         if (phase == 3) send_frame(515, FRAME_GOOD, -1);   // both counters saturate
         while (bytes_sent - start_count < 40) send_random_frame();
         drain();
      end
      idle_on = 1'b1;

      // allow for anything the block might still emit
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes; checked %0d payload bytes and %0d verdicts",
               bytes_sent, sb.payloads, sb.frames);
      $display("Verdicts ok/short/proto/len/csum: %0d/%0d/%0d/%0d/%0d",
               sb.status_seen[xcfd_pkg::STATUS_OK],
               sb.status_seen[xcfd_pkg::STATUS_TOO_SHORT],
               sb.status_seen[xcfd_pkg::STATUS_BAD_PROTO],
               sb.status_seen[xcfd_pkg::STATUS_BAD_LEN],
               sb.status_seen[xcfd_pkg::STATUS_BAD_CSUM]);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding", sb.pending.size());
      $display("FAIL");
      $finish;
   end

endmodule
